### rtl/hrfh_pkg.sv
// Package: shared constants, types and the hex digit conversion for the record parser.
package hrfh_pkg;

  localparam logic [15:0] UPPER_ADDRESS_RESET = 16'h0800;
  localparam logic [7:0]  CHAR_COLON          = 8'h3A;
  localparam logic [7:0]  CHAR_ZERO           = 8'h30;
  localparam logic [7:0]  CHAR_NINE           = 8'h39;

  // character positions inside a record
  localparam logic [9:0]  POS_MAX        = 10'd1023;
  localparam logic [9:0]  POS_COUNT_HI   = 10'd1;
  localparam logic [9:0]  POS_COUNT_LO   = 10'd2;
  localparam logic [9:0]  POS_ADDR_FIRST = 10'd3;
  localparam logic [9:0]  POS_ADDR_LAST  = 10'd6;
  localparam logic [9:0]  POS_TYPE       = 10'd8;
  localparam logic [9:0]  POS_DATA_FIRST = 10'd9;

  typedef struct packed {
    logic [31:0] flash_address;
    logic [15:0] halfword;
    logic        last_in_record;
  } hrfh_word_t;

  typedef struct packed {
    logic       emit;
    hrfh_word_t word;
  } hrfh_result_t;

  // digit: c-48, else c-55, low four bits only
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

### rtl/hrfh_char_if.sv
// Interface: character channel into the parser.
interface hrfh_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source  (output valid, output character, input ready);
  modport sink    (input valid, input character, output ready);
  modport monitor (input valid, input character, input ready);
endinterface

### rtl/hrfh_word_if.sv
// Interface: flash halfword channel out of the parser.
interface hrfh_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] flash_address;
  logic [15:0] halfword;
  logic        last_in_record;

  modport source  (output valid, output flash_address, output halfword,
                   output last_in_record, input ready);
  modport sink    (input valid, input flash_address, input halfword,
                   input last_in_record, output ready);
  modport monitor (input valid, input flash_address, input halfword,
                   input last_in_record, input ready);
endinterface

### rtl/hex_record_to_flash_halfwords_unit.sv
// Top level: HEX record text in, flash halfword words out.
// Path: a character is registered in the character stage at acceptance; its word, if
//   any, is loaded into the output register when that stage moves on.
// Throughput: one character per cycle; the only stall is a full output register
//   whose word is not taken, which holds the character stage and drops chars.ready.
// Reset (rst, synchronous, active high): parse state cleared, both stages empty,
//   upper_address back to 0x0800.
module hex_record_to_flash_halfwords_unit
  import hrfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hrfh_char_if.sink   chars,
  hrfh_word_if.source words,
  input  logic        wr_en,
  input  logic [15:0] wr_data
);

  logic [15:0]  upper_address;

  // character stage
  logic         s1_valid;
  logic [7:0]   s1_char;

  // output register
  logic         out_valid;
  hrfh_word_t   out_word;

  logic         proceed;
  hrfh_result_t result;

  // the character stage moves on whenever the output register can take a word
  assign proceed     = s1_valid && (!out_valid || words.ready);
  assign chars.ready = !s1_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_address <= UPPER_ADDRESS_RESET;
    end else if (wr_en) begin
      upper_address <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.character;
    end
  end

  hrfh_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (proceed),
    .character     (s1_char),
    .upper_address (upper_address),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && result.emit) begin
      out_valid <= 1'b1;
    end else if (words.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (proceed && result.emit) begin
      out_word <= result.word;
    end
  end

  assign words.valid          = out_valid;
  assign words.flash_address  = out_word.flash_address;
  assign words.halfword       = out_word.halfword;
  assign words.last_in_record = out_word.last_in_record;

endmodule

### rtl/hrfh_parser.sv
// Record parse state and the per-character word computation.
module hrfh_parser
  import hrfh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   character,
  input  logic [15:0]  upper_address,
  output hrfh_result_t result
);

  logic [9:0]  char_position;
  logic        in_record;
  logic [7:0]  byte_count;
  logic [15:0] low_address;
  logic        is_data_record;
  logic [11:0] nibble_store;
  logic [6:0]  word_index;

  logic        is_colon;
  logic [9:0]  pos_next;
  logic [3:0]  d;
  logic [6:0]  total;
  logic        data_slot;
  logic        fourth_digit;
  logic [15:0] digits;

  assign is_colon  = (character == CHAR_COLON);
  assign pos_next  = (char_position == POS_MAX) ? char_position : char_position + 10'd1;
  assign d         = hex_nibble(character);
  assign total     = byte_count[7:1];
  assign data_slot = in_record && !is_colon && (pos_next >= POS_DATA_FIRST)
                     && is_data_record && (word_index < total);
  // (p-9) mod 4 == 3  <=>  p mod 4 == 0
  assign fourth_digit = (pos_next[1:0] == 2'b00);
  assign digits       = {nibble_store, d};

  always_comb begin
    result.emit                = data_slot && fourth_digit;
    result.word.flash_address  = {upper_address, low_address}
                                 + {24'd0, word_index, 1'b0};
    result.word.halfword       = {digits[7:0], digits[15:8]};
    result.word.last_in_record = (({1'b0, word_index} + 8'd1) == {1'b0, total});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      in_record      <= 1'b0;
      byte_count     <= '0;
      low_address    <= '0;
      is_data_record <= 1'b0;
      nibble_store   <= '0;
      word_index     <= '0;
    end else if (step) begin
      if (is_colon) begin
        in_record      <= 1'b1;
        char_position  <= '0;
        word_index     <= '0;
        nibble_store   <= '0;
        is_data_record <= 1'b0;
      end else if (in_record) begin
        char_position <= pos_next;
        if (pos_next == POS_COUNT_HI) begin
          byte_count <= {d, 4'd0};
        end else if (pos_next == POS_COUNT_LO) begin
          byte_count <= byte_count | {4'd0, d};
        end else if (pos_next >= POS_ADDR_FIRST && pos_next <= POS_ADDR_LAST) begin
          low_address <= {low_address[11:0], d};
        end else if (pos_next == POS_TYPE) begin
          is_data_record <= (character == CHAR_ZERO);
          word_index     <= '0;
          nibble_store   <= '0;
        end else if (data_slot) begin
          if (fourth_digit) begin
            word_index   <= word_index + 7'd1;
            nibble_store <= '0;
          end else begin
            nibble_store <= digits[11:0];
          end
        end
      end
    end
  end

endmodule

### rtl/hrfh_checker.sv
// Checker: port-level properties of the record parser, bound to the top level.
module hrfh_checker (
  input logic        clk,
  input logic        rst,
  input logic        chars_valid,
  input logic        chars_ready,
  input logic        words_valid,
  input logic        words_ready,
  input logic [31:0] flash_address,
  input logic [15:0] halfword,
  input logic        last_in_record
);

  // a stalled word holds
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    words_valid && !words_ready |=> words_valid
      && $stable(flash_address) && $stable(halfword)
      && $stable(last_in_record))
    else $error("stalled word changed");

  // input backpressure only comes from a word waiting at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !chars_ready |-> words_valid && !words_ready)
    else $error("chars.ready low without a stalled word");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !words_valid && chars_ready)
    else $error("pipeline not empty after reset");

  // character stage left empty last cycle: a taken word leaves the output empty
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    words_valid && words_ready && $past(chars_ready && !chars_valid)
      && !$past(rst) |=> !words_valid)
    else $error("word appeared without a character");

endmodule

bind hex_record_to_flash_halfwords_unit hrfh_checker u_hrfh_checker (
  .clk            (clk),
  .rst            (rst),
  .chars_valid    (chars.valid),
  .chars_ready    (chars.ready),
  .words_valid    (words.valid),
  .words_ready    (words.ready),
  .flash_address  (words.flash_address),
  .halfword       (words.halfword),
  .last_in_record (words.last_in_record)
);

### verif/hex_record_to_flash_halfwords_unit_tb.sv
// Testbench: HEX record text through the halfword parser, checked against a local predictor.
`timescale 1ns / 100ps

module hex_record_to_flash_halfwords_unit_tb;
  import hrfh_pkg::*;

  // ---------------------------------------------------------------------------
  // Timing constants
  // ---------------------------------------------------------------------------
  localparam int RESET_CYCLES = 10;
  // Output register sits behind the character stage; a little margin on top.
  localparam int DRAIN_PAUSE  = 4;
  // Longest deliberate receiver hold-off, used to back the block up.
  localparam int HOLD_CYCLES  = 100;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASES       = 8;
  localparam int PRESSURE_PH  = 4;

  // Non-digits convert as character minus this.
  localparam logic [7:0] HEX_LETTER_BIAS = 8'd55;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam string      HEX_DIGITS      = "0123456789ABCDEFabcdef";

  // ---------------------------------------------------------------------------
  // Clock, reset, configuration port and the two channels
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [15:0] wr_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hrfh_char_if chars_bus ();
  hrfh_word_if words_bus ();

  hex_record_to_flash_halfwords_unit dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_bus),
    .words   (words_bus),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the parse state and the upper address
  // ---------------------------------------------------------------------------
  logic [15:0] model_upper;
  logic [9:0]  char_pos;
  logic        in_rec;
  logic [7:0]  rec_count;
  logic [15:0] rec_low;
  logic        rec_data;
  logic [11:0] digit_acc;
  logic [6:0]  words_done;

  hrfh_word_t  expected_halfwords [$];
  logic [7:0]  char_q [$];

  int          chars_queued = 0;
  int          chars_taken  = 0;
  int          words_seen   = 0;
  int          failures     = 0;
  hrfh_word_t  last_word;

  // Idling knobs: the percentages are changed by the sequencer between phases.
  int          sender_gap_pct = 0;
  int          recv_stall_pct = 0;
  logic        pressure_go    = 1'b0;
  logic        hold_off       = 1'b0;

  // ---------------------------------------------------------------------------
  // Directed text: one row per record-ish fragment. Rows marked pinned make
  // exactly one word whose value is typed in; the rest rely on the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    string      text;
    int         fill;    // random hex digits appended after the text
    int         upper;   // register value written first, -1 for none
    bit         pinned;
    hrfh_word_t word;
  } text_row_t;

  localparam int ROWS = 15;

  text_row_t text_rows [ROWS] = '{
    // junk before any colon is dropped, includes the top character code
    '{"AB\377z",               0,   -1, 1'b0, '0},
    // smallest data record straight after reset, default upper half
    '{":02000000ABCD",         0,   -1, 1'b1, '{32'h0800_0000, 16'hCDAB, 1'b1}},
    // two halfwords, then checksum chars ignored once the record is done
    '{":041234001122334455",   0,   -1, 1'b0, '0},
    // non-data record type
    '{":0200000100FF",         0,   -1, 1'b0, '0},
    // byte counts of one and zero give nothing
    '{":0100000012",           0,   -1, 1'b0, '0},
    '{":00000000",             0,   -1, 1'b0, '0},
    // odd count: trailing byte dropped, the single halfword is the last
    '{":03000000AABBCC",       0,   -1, 1'b1, '{32'h0800_0000, 16'hBBAA, 1'b1}},
    // colon mid-record restarts the parse
    '{":0400:02000000FFFF",    0,   -1, 1'b1, '{32'h0800_0000, 16'hFFFF, 1'b1}},
    // non-hex and lower-case characters go through the plain conversion
    '{":04000000gh!~a.Zq",     0,   -1, 1'b0, '0},
    // top of the address space, then a record that wraps past it
    '{":02FFFE000102",         0, 'hFFFF, 1'b1, '{32'hFFFF_FFFE, 16'h0201, 1'b1}},
    '{":04FFFE0001020304",     0,   -1, 1'b0, '0},
    // bottom of the address space
    '{":02000000FFFF",         0,    0, 1'b1, '{32'h0000_0000, 16'hFFFF, 1'b1}},
    // largest byte count: 127 halfwords
    '{":FFFFFF00",           508, 'h1234, 1'b0, '0},
    // long non-data record runs the position counter into saturation
    '{":02000005",          1100,   -1, 1'b0, '0},
    // line ending between records, all-zero halfword
    '{"\r\n:020000000000",     0,   -1, 1'b1, '{32'h1234_0000, 16'h0000, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else begin
      v = c - HEX_LETTER_BIAS;
    end
    return v[3:0];
  endfunction

  task automatic reset_model();
    model_upper = UPPER_ADDRESS_RESET;
    char_pos    = '0;
    in_rec      = 1'b0;
    rec_count   = '0;
    rec_low     = '0;
    rec_data    = 1'b0;
    digit_acc   = '0;
    words_done  = '0;
  endtask

  // Advance the parse by one accepted character; queue the halfword it completes.
  task automatic parse_char(input logic [7:0] c);
    logic [3:0]  d;
    logic [6:0]  total;
    logic [9:0]  offset;
    logic [15:0] digits;
    hrfh_word_t  w;
    if (c == CHAR_COLON) begin
      in_rec     = 1'b1;
      char_pos   = '0;
      words_done = '0;
      digit_acc  = '0;
      rec_data   = 1'b0;
    end else if (in_rec) begin
      if (char_pos != POS_MAX) begin
        char_pos = char_pos + 10'd1;
      end
      d = digit_value(c);
      if (char_pos == POS_COUNT_HI) begin
        rec_count = {d, 4'h0};
      end else if (char_pos == POS_COUNT_LO) begin
        rec_count = rec_count | {4'h0, d};
      end else if (char_pos >= POS_ADDR_FIRST && char_pos <= POS_ADDR_LAST) begin
        rec_low = {rec_low[11:0], d};
      end else if (char_pos == POS_TYPE) begin
        rec_data   = (c == CHAR_ZERO);
        words_done = '0;
        digit_acc  = '0;
      end else if (char_pos >= POS_DATA_FIRST && rec_data) begin
        total  = rec_count[7:1];
        offset = char_pos - POS_DATA_FIRST;
        if (words_done < total) begin
          if (offset[1:0] != 2'd3) begin
            digit_acc = {digit_acc[7:0], d};
          end else begin
            // first two digits are the low byte, the next two the high byte
            digits           = {digit_acc, d};
            w.flash_address  = {model_upper, rec_low} + {24'h0, words_done, 1'b0};
            w.halfword       = {digits[7:0], digits[15:8]};
            w.last_in_record = ({1'b0, words_done} + 8'd1) == {1'b0, total};
            expected_halfwords.push_back(w);
            words_done = words_done + 7'd1;
            digit_acc  = '0;
          end
        end
      end
    end
  endtask

  // Field-by-field comparison, shared by the scoreboard and the pinned rows.
  function automatic void check_word(input hrfh_word_t exp_w, input hrfh_word_t got_w);
    if (got_w.flash_address !== exp_w.flash_address) begin
      $error("flash_address: expected %h, got %h", exp_w.flash_address, got_w.flash_address);
      failures++;
    end
    if (got_w.halfword !== exp_w.halfword) begin
      $error("halfword: expected %h, got %h", exp_w.halfword, got_w.halfword);
      failures++;
    end
    if (got_w.last_in_record !== exp_w.last_in_record) begin
      $error("last_in_record: expected %b, got %b", exp_w.last_in_record,
             got_w.last_in_record);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_char(input logic [7:0] c);
    char_q.push_back(c);
    chars_queued++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CHAR_ZERO + 8'(v) : HEX_LETTER_BIAS + 8'(v);
  endfunction

  function automatic logic [7:0] any_hex();
    return HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)];
  endfunction

  // Queue one random record (or a burst of noise). Returns the number of
  // record characters queued, leaving out noise and line endings.
  function automatic int queue_random_record();
    logic [7:0]  rec [$];
    logic [7:0]  nbytes;
    logic [15:0] low;
    int          roll;
    int          keep;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // loose bytes between records
      repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(0, 255)));
      return 0;
    end
    // mostly short records, the odd longer one
    nbytes = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                         : 8'($urandom_range(0, 8));
    low    = ($urandom_range(0, 3) == 0) ? (16'hFFF0 | 16'($urandom_range(0, 15)))
                                         : 16'($urandom_range(0, 65535));
    rec.push_back(CHAR_COLON);
    rec.push_back(hex_char(nbytes[7:4]));
    rec.push_back(hex_char(nbytes[3:0]));
    for (int k = 3; k >= 0; k--) rec.push_back(hex_char(low[k*4 +: 4]));
    rec.push_back(CHAR_ZERO);
    if ($urandom_range(0, 99) < 85) begin
      rec.push_back(CHAR_ZERO);
    end else if ($urandom_range(0, 1) == 0) begin
      rec.push_back(any_hex());
    end else begin
      rec.push_back(8'($urandom_range(0, 255)));
    end
    for (int k = 0; k < 2 * nbytes; k++) begin
      rec.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : any_hex());
    end
    rec.push_back(any_hex());
    rec.push_back(any_hex());
    // broken record: chopped short, the next colon picks up from there
    keep = (roll < 18) ? $urandom_range(1, rec.size() - 1) : rec.size();
    for (int k = 0; k < keep; k++) queue_char(rec[k]);
    if ($urandom_range(0, 1) == 0) begin
      queue_char(CHAR_CR);
      queue_char(CHAR_LF);
    end
    return keep;
  endfunction

  // Block is idle once every queued character is taken and every halfword seen;
  // the pause covers a character still in flight that makes no word.
  task automatic wait_drained();
    while (chars_taken != chars_queued || expected_halfwords.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_upper(input logic [15:0] value);
    @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en   <= 1'b0;
    model_upper = value;
  endtask

  // ---------------------------------------------------------------------------
  // Character sender: presents the next queued character, holds it until it
  // is taken, and feeds every accepted character into the predictor.
  // ---------------------------------------------------------------------------
  initial begin : char_sender
    chars_bus.valid     = 1'b0;
    chars_bus.character = '0;
    forever begin
      @(posedge clk);
      if (rst) begin
        chars_bus.valid <= 1'b0;
      end else begin
        if (chars_bus.valid && chars_bus.ready) begin
          parse_char(chars_bus.character);
          chars_taken++;
        end
        // slot is free unless the current character is still waiting
        if (!chars_bus.valid || chars_bus.ready) begin
          if (char_q.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
            chars_bus.valid     <= 1'b1;
            chars_bus.character <= char_q.pop_front();
          end else begin
            chars_bus.valid <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Halfword receiver: random stalls, plus the long hold-off when asked.
  // ---------------------------------------------------------------------------
  initial begin : word_receiver
    words_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        words_bus.ready <= 1'b0;
      end else begin
        words_bus.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Long hold-off, counted here so the sender keeps offering meanwhile.
  initial begin : receiver_hold
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: each halfword word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hrfh_word_t got_w;
    if (!rst && words_bus.valid && words_bus.ready) begin
      got_w.flash_address  = words_bus.flash_address;
      got_w.halfword       = words_bus.halfword;
      got_w.last_in_record = words_bus.last_in_record;
      last_word = got_w;
      words_seen++;
      if (expected_halfwords.size() == 0) begin
        $error("unexpected halfword: address %h, data %h", got_w.flash_address,
               got_w.halfword);
        failures++;
      end else begin
        check_word(expected_halfwords.pop_front(), got_w);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no transfer on either channel ends the run.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (chars_bus.valid && chars_bus.ready) || (words_bus.valid && words_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed rows, then random phases under varied idling.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int counted;
    int target;
    int seen_at_start;
    rst     = 1'b1;
    wr_en   = 1'b0;
    wr_data = '0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed rows, one at a time with the block drained in between
    foreach (text_rows[i]) begin
      if (text_rows[i].upper >= 0) begin
        write_upper(16'(text_rows[i].upper));
      end
      seen_at_start = words_seen;
      for (int k = 0; k < text_rows[i].text.len(); k++) queue_char(text_rows[i].text[k]);
      repeat (text_rows[i].fill) queue_char(any_hex());
      wait_drained();
      if (text_rows[i].pinned) begin
        if (words_seen != seen_at_start + 1) begin
          $error("row %0d: expected one halfword, got %0d", i, words_seen - seen_at_start);
          failures++;
        end else begin
          check_word(text_rows[i].word, last_word);
        end
      end
    end

    // random phases: idling mode cycles through none / sender / receiver / both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          sender_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 45;
          recv_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          recv_stall_pct = 45;
        end
        default: begin
          sender_gap_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      // top and bottom of the upper half late on, random before that
      if (ph == PHASES - 2) begin
        write_upper(16'hFFFF);
      end else if (ph == PHASES - 1) begin
        write_upper(16'h0000);
      end else begin
        write_upper(16'($urandom_range(0, 65535)));
      end
      target  = (ph == PRESSURE_PH) ? 110 : 50;
      counted = 0;
      while (counted < target) counted += queue_random_record();
      // back-pressure: receiver stops while a full queue of text keeps coming
      if (ph == PRESSURE_PH) begin
        pressure_go = 1'b1;
      end
      wait_drained();
    end

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hrfh_pkg.sv
rtl/hrfh_char_if.sv
rtl/hrfh_word_if.sv
rtl/hrfh_parser.sv
rtl/hex_record_to_flash_halfwords_unit.sv
rtl/hrfh_checker.sv
verif/hex_record_to_flash_halfwords_unit_tb.sv
